@@ hw/rtl/two_wire_debug_command_master_core_defines.svh @@
// Assertion macros shared by the checker of the two-wire debug command master.
`ifndef TWO_WIRE_DEBUG_COMMAND_MASTER_CORE_DEFINES_SVH
`define TWO_WIRE_DEBUG_COMMAND_MASTER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TWDCM_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("twdcm assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TWDCM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("twdcm assertion failed");

`endif

@@ hw/rtl/twdcm_pkg.sv @@
// Types and constants of the two-wire debug command master.
package twdcm_pkg;

  // Highest number of argument bytes that follow the command byte.
  localparam logic [1:0] MAX_ARGS = 2'd3;

  // Value of the ready poll limit after reset.
  localparam logic [7:0] POLL_LIMIT_RESET = 8'd16;

  // Largest value of the poll counter; it saturates there.
  localparam logic [7:0] POLL_COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic       kind;
    logic       dd_in;
    logic [7:0] command_byte;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
    logic [7:0] arg_third;
    logic [1:0] arg_count;
  } twdcm_in_t;

  typedef struct packed {
    logic       clock_level;
    logic       data_level;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] reply;
    logic       timed_out;
  } twdcm_out_t;

endpackage

@@ hw/rtl/twdcm_step.sv @@
// Transfer state and next-state logic: one item is processed per advance.
module twdcm_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv_i,
  input  twdcm_pkg::twdcm_in_t  item_i,
  input  logic [7:0]            poll_limit_i,
  output twdcm_pkg::twdcm_out_t res_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WRITE,
    PH_CHECK,
    PH_DUMMY,
    PH_REPLY
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic [2:0][7:0] arg_r, arg_nxt;
  logic [1:0]      left_r, left_nxt;
  logic [2:0]      bit_r, bit_nxt;
  logic            half_r, half_nxt;
  logic [7:0]      poll_r, poll_nxt;
  logic            tmo_r, tmo_nxt;
  logic            dc_r, dc_nxt;
  logic            ddl_r, ddl_nxt;
  logic            ddd_r, ddd_nxt;
  logic            done;
  logic [7:0]      reply;
  logic            bit_last;
  logic [1:0]      n_args;

  assign bit_last = (bit_r == 3'd7);
  assign n_args   = (item_i.arg_count > twdcm_pkg::MAX_ARGS) ? twdcm_pkg::MAX_ARGS
                                                             : item_i.arg_count;

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    arg_nxt   = arg_r;
    left_nxt  = left_r;
    bit_nxt   = bit_r;
    half_nxt  = half_r;
    poll_nxt  = poll_r;
    tmo_nxt   = tmo_r;
    dc_nxt    = dc_r;
    ddl_nxt   = ddl_r;
    ddd_nxt   = ddd_r;
    done      = 1'b0;
    reply     = 8'd0;
    if (item_i.kind) begin
      // A start is taken only when no command is running.
      if (phase_r == PH_IDLE) begin
        shift_nxt = item_i.command_byte;
        arg_nxt   = {item_i.arg_third, item_i.arg_second, item_i.arg_first};
        left_nxt  = n_args;
        bit_nxt   = 3'd0;
        half_nxt  = 1'b0;
        poll_nxt  = 8'd0;
        tmo_nxt   = 1'b0;
        phase_nxt = PH_WRITE;
        dc_nxt    = 1'b0;
        ddd_nxt   = 1'b1;
        ddl_nxt   = item_i.command_byte[7];
      end
    end else begin
      unique case (phase_r)
        PH_WRITE: begin
          ddd_nxt = 1'b1;
          if (!half_r) begin
            ddl_nxt  = shift_r[7];
            dc_nxt   = 1'b1;
            half_nxt = 1'b1;
          end else begin
            shift_nxt = {shift_r[6:0], 1'b0};
            dc_nxt    = 1'b0;
            half_nxt  = 1'b0;
            bit_nxt   = bit_r + 3'd1;
            if (bit_last) begin
              if (left_r != 2'd0) begin
                shift_nxt  = arg_r[0];
                arg_nxt[0] = arg_r[1];
                arg_nxt[1] = arg_r[2];
                left_nxt   = left_r - 2'd1;
              end else begin
                phase_nxt = PH_CHECK;
                ddd_nxt   = 1'b0;
                ddl_nxt   = 1'b0;
              end
            end
          end
        end
        PH_CHECK: begin
          dc_nxt   = 1'b0;
          ddd_nxt  = 1'b0;
          ddl_nxt  = 1'b0;
          bit_nxt  = 3'd0;
          half_nxt = 1'b0;
          if (poll_r >= poll_limit_i) begin
            tmo_nxt   = 1'b1;
            shift_nxt = 8'd0;
            phase_nxt = PH_REPLY;
          end else if (item_i.dd_in) begin
            phase_nxt = PH_DUMMY;
          end else begin
            shift_nxt = 8'd0;
            phase_nxt = PH_REPLY;
          end
        end
        PH_DUMMY: begin
          if (!half_r) begin
            dc_nxt   = 1'b1;
            half_nxt = 1'b1;
          end else begin
            dc_nxt   = 1'b0;
            half_nxt = 1'b0;
            bit_nxt  = bit_r + 3'd1;
            if (bit_last) begin
              if (poll_r != twdcm_pkg::POLL_COUNT_MAX) begin
                poll_nxt = poll_r + 8'd1;
              end
              phase_nxt = PH_CHECK;
            end
          end
        end
        PH_REPLY: begin
          if (!half_r) begin
            // The target's bit is taken while the clock is high.
            dc_nxt    = 1'b1;
            half_nxt  = 1'b1;
            shift_nxt = {shift_r[6:0], item_i.dd_in};
          end else begin
            dc_nxt   = 1'b0;
            half_nxt = 1'b0;
            bit_nxt  = bit_r + 3'd1;
            if (bit_last) begin
              done      = 1'b1;
              reply     = shift_r;
              phase_nxt = PH_IDLE;
              ddd_nxt   = 1'b1;
              ddl_nxt   = 1'b0;
            end
          end
        end
        PH_IDLE: begin
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res_o.clock_level = dc_nxt;
    res_o.data_level  = ddd_nxt & ddl_nxt;
    res_o.data_drive  = ddd_nxt;
    res_o.busy_res    = (phase_nxt != PH_IDLE);
    res_o.done_res    = done;
    res_o.reply       = reply;
    res_o.timed_out   = tmo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      shift_r <= 8'd0;
      left_r  <= 2'd0;
      bit_r   <= 3'd0;
      half_r  <= 1'b0;
      poll_r  <= 8'd0;
      tmo_r   <= 1'b0;
      dc_r    <= 1'b0;
      ddl_r   <= 1'b0;
      ddd_r   <= 1'b1;
    end else if (adv_i) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
      bit_r   <= bit_nxt;
      half_r  <= half_nxt;
      poll_r  <= poll_nxt;
      tmo_r   <= tmo_nxt;
      dc_r    <= dc_nxt;
      ddl_r   <= ddl_nxt;
      ddd_r   <= ddd_nxt;
    end
  end

  // Argument bytes are only read after a start has written them.
  always_ff @(posedge clk) begin
    if (adv_i) begin
      arg_r <= arg_nxt;
    end
  end

endmodule

@@ hw/rtl/two_wire_debug_command_master_core.sv @@
// Top level of the two-wire debug command master.
//
// The block drives a debug clock line (DC) and a data line (DD) that it can
// release. An input item is either a start (kind = 1), which loads a command
// byte and up to three argument bytes, or a tick (kind = 0), which moves the
// transfer on by one half bit and carries the sampled DD level. A start that
// arrives while a command runs is ignored. Every input item gives exactly one
// result item with the line levels after it, busy, done, reply and timeout.
// The ready poll limit is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce it.
//
// An accepted item is held in the input register, processed by the next-state
// logic and lands in the output register. One item is taken every cycle while
// the output is not stalled. When out_stall holds the output register, the
// input register still takes one more item and in_stall rises only once both
// are full. A synchronous reset (rst_n low) empties both registers, sets the
// poll limit to 16, returns the transfer to idle and drives DC low and DD low.
module two_wire_debug_command_master_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  twdcm_pkg::twdcm_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output twdcm_pkg::twdcm_out_t out_data,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data
);

  logic                  in_valid_r;
  twdcm_pkg::twdcm_in_t  in_data_r;
  logic                  out_valid_r;
  twdcm_pkg::twdcm_out_t out_data_r;
  twdcm_pkg::twdcm_out_t res;
  logic [7:0]            poll_limit_r;
  logic                  adv;
  logic                  in_acc;

  // The held item moves on whenever the output register is empty or drains.
  assign adv      = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = in_valid_r & ~adv;
  assign in_acc   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= twdcm_pkg::POLL_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      poll_limit_r <= cfg_wr_data;
    end
  end

  twdcm_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv_i        (adv),
    .item_i       (in_data_r),
    .poll_limit_i (poll_limit_r),
    .res_o        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/twdcm_checker.sv @@
// Port checker for the two-wire debug command master, bound to the top level.
`include "two_wire_debug_command_master_core_defines.svh"

module twdcm_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input twdcm_pkg::twdcm_out_t out_data
);

  // A stalled result stays in place.
  `TWDCM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // The data line can only be high while the master drives it.
  `TWDCM_ASSERT_IMPL(a_level_driven, clk, rst_n, out_valid && out_data.data_level, out_data.data_drive)

  // The reply completes with the command over, DC low and DD driven again.
  `TWDCM_ASSERT_IMPL(a_done_idle, clk, rst_n, out_valid && out_data.done_res, !out_data.busy_res && !out_data.clock_level && out_data.data_drive)

  // The reply byte is zero on every result that does not complete a command.
  `TWDCM_ASSERT_IMPL(a_reply_zero, clk, rst_n, out_valid && !out_data.done_res, out_data.reply == 8'd0)

endmodule

bind two_wire_debug_command_master_core twdcm_checker u_twdcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/two_wire_debug_command_master_core_test.sv @@
// Testbench for the two-wire debug command master: predicts every item and checks it.
`timescale 1ns / 1ps

module two_wire_debug_command_master_core_test;

  // Run length and safety limits. The watchdog limit is several times the
  // longest quiet stretch a correct run can show: a receiver hold-off of
  // HOLD_CYCLES plus the longest random gap on either side.
  localparam int RANDOM_ITEMS   = 60;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;

  // Transfer phases of the predictor, in the same order the block steps
  // through them.
  typedef enum logic [2:0] {
    XFER_IDLE,
    XFER_WRITE,
    XFER_READY_CHECK,
    XFER_DUMMY_READ,
    XFER_REPLY_READ
  } xfer_phase_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  twdcm_pkg::twdcm_in_t  in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  twdcm_pkg::twdcm_out_t out_data;
  logic                  cfg_wr_en;
  logic [7:0]            cfg_wr_data;

  two_wire_debug_command_master_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Predicted state of the master. It is advanced once per accepted item,
  // in the order the items were accepted.
  xfer_phase_t mdl_phase;
  logic [7:0]  mdl_shift;
  logic [7:0]  mdl_args [3];
  logic [1:0]  mdl_bytes_left;
  logic [2:0]  mdl_bit_idx;
  logic        mdl_half;
  logic [7:0]  mdl_polls;
  logic        mdl_timeout;
  logic        mdl_dc;
  logic        mdl_dd;
  logic        mdl_dd_drive;
  logic [7:0]  mdl_poll_limit;

  // Line levels expected for items that were accepted but whose result item
  // has not been seen yet, oldest first.
  twdcm_pkg::twdcm_out_t expected_levels_q [$];

  // Knobs for idling, shared by the test tasks and the receiver process.
  bit sender_gaps_on     = 1'b1;
  bit receiver_stalls_on = 1'b1;
  int hold_request       = 0;
  int stall_left         = 0;

  // Bookkeeping for the summary and the verdict.
  int mismatches        = 0;
  int items_sent        = 0;
  int active_items      = 0;
  int commands_run      = 0;
  int results_checked   = 0;
  int ready_timeouts    = 0;
  int input_held_cycles = 0;
  int quiet_cycles      = 0;

  function automatic void reset_predictor();
    mdl_phase      = XFER_IDLE;
    mdl_shift      = '0;
    mdl_args       = '{default: '0};
    mdl_bytes_left = '0;
    mdl_bit_idx    = '0;
    mdl_half       = 1'b0;
    mdl_polls      = '0;
    mdl_timeout    = 1'b0;
    mdl_dc         = 1'b0;
    mdl_dd         = 1'b0;
    mdl_dd_drive   = 1'b1;
    mdl_poll_limit = twdcm_pkg::POLL_LIMIT_RESET;
  endfunction

  // One half of a serial bit: DC rises on the first half (where a read
  // samples DD) and falls on the second. Returns 1 once the eighth bit ends.
  function automatic bit advance_half_bit(logic dd, bit sample);
    if (!mdl_half) begin
      mdl_dc = 1'b1;
      if (sample) mdl_shift = {mdl_shift[6:0], dd};
      mdl_half = 1'b1;
      return 1'b0;
    end
    mdl_dc      = 1'b0;
    mdl_half    = 1'b0;
    mdl_bit_idx = mdl_bit_idx + 3'd1;
    return mdl_bit_idx == 3'd0;
  endfunction

  // Applies one accepted item to the predicted state and returns the line
  // levels and status the block should report for it.
  function automatic twdcm_pkg::twdcm_out_t predict_line_levels(twdcm_pkg::twdcm_in_t item);
    twdcm_pkg::twdcm_out_t res;
    logic                  done;
    logic [7:0]            reply_byte;
    done       = 1'b0;
    reply_byte = '0;
    if (item.kind) begin
      // A start only takes effect when no command is running.
      if (mdl_phase == XFER_IDLE) begin
        mdl_shift      = item.command_byte;
        mdl_args[0]    = item.arg_first;
        mdl_args[1]    = item.arg_second;
        mdl_args[2]    = item.arg_third;
        mdl_bytes_left = (item.arg_count > twdcm_pkg::MAX_ARGS) ? twdcm_pkg::MAX_ARGS
                                                                : item.arg_count;
        mdl_bit_idx    = '0;
        mdl_half       = 1'b0;
        mdl_polls      = '0;
        mdl_timeout    = 1'b0;
        mdl_phase      = XFER_WRITE;
        mdl_dc         = 1'b0;
        mdl_dd_drive   = 1'b1;
        mdl_dd         = item.command_byte[7];
      end
    end else begin
      case (mdl_phase)
        XFER_WRITE: begin
          mdl_dd_drive = 1'b1;
          if (!mdl_half) begin
            mdl_dd = mdl_shift[7];
            void'(advance_half_bit(item.dd_in, 1'b0));
          end else begin
            mdl_shift = mdl_shift << 1;
            if (advance_half_bit(item.dd_in, 1'b0)) begin
              if (mdl_bytes_left != 2'd0) begin
                mdl_shift      = mdl_args[0];
                mdl_args[0]    = mdl_args[1];
                mdl_args[1]    = mdl_args[2];
                mdl_bytes_left = mdl_bytes_left - 2'd1;
              end else begin
                mdl_phase    = XFER_READY_CHECK;
                mdl_dd_drive = 1'b0;
                mdl_dd       = 1'b0;
              end
            end
          end
        end
        XFER_READY_CHECK: begin
          mdl_dc       = 1'b0;
          mdl_dd_drive = 1'b0;
          mdl_dd       = 1'b0;
          mdl_bit_idx  = '0;
          mdl_half     = 1'b0;
          if (mdl_polls >= mdl_poll_limit) begin
            mdl_timeout = 1'b1;
            mdl_shift   = '0;
            mdl_phase   = XFER_REPLY_READ;
            ready_timeouts++;
          end else if (item.dd_in) begin
            mdl_phase = XFER_DUMMY_READ;
          end else begin
            mdl_shift = '0;
            mdl_phase = XFER_REPLY_READ;
          end
        end
        XFER_DUMMY_READ: begin
          if (advance_half_bit(item.dd_in, 1'b0)) begin
            if (mdl_polls < twdcm_pkg::POLL_COUNT_MAX) mdl_polls = mdl_polls + 8'd1;
            mdl_phase = XFER_READY_CHECK;
          end
        end
        XFER_REPLY_READ: begin
          if (advance_half_bit(item.dd_in, 1'b1)) begin
            done         = 1'b1;
            reply_byte   = mdl_shift;
            mdl_phase    = XFER_IDLE;
            mdl_dd_drive = 1'b1;
            mdl_dd       = 1'b0;
          end
        end
        default: ;
      endcase
    end
    res.clock_level = mdl_dc;
    res.data_level  = mdl_dd_drive ? mdl_dd : 1'b0;
    res.data_drive  = mdl_dd_drive;
    res.busy_res    = (mdl_phase != XFER_IDLE);
    res.done_res    = done;
    res.reply       = reply_byte;
    res.timed_out   = mdl_timeout;
    return res;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic twdcm_pkg::twdcm_in_t random_item();
    twdcm_pkg::twdcm_in_t item;
    item.kind         = 1'($urandom_range(0, 1));
    item.dd_in        = 1'($urandom_range(0, 1));
    item.command_byte = 8'($urandom_range(0, 255));
    item.arg_first    = 8'($urandom_range(0, 255));
    item.arg_second   = 8'($urandom_range(0, 255));
    item.arg_third    = 8'($urandom_range(0, 255));
    item.arg_count    = 2'($urandom_range(0, 3));
    return item;
  endfunction

  // Offers one item, waits for the handshake, records what it should give,
  // then optionally leaves a gap. It is entered just after a rising edge, so
  // the valid set here is seen at the following edge.
  task automatic send_item(input twdcm_pkg::twdcm_in_t item);
    twdcm_pkg::twdcm_out_t want;
    int                    gap;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    want = predict_line_levels(item);
    expected_levels_q.push_back(want);
    items_sent++;
    if (want.busy_res || want.done_res) active_items++;
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Runs one command to its end. The target's answers are shaped from the
  // predicted state: it stays busy for busy_polls ready checks, and it
  // presents reply_val bit by bit on the ticks where DC rises. Every other
  // tick carries a random DD level, and stray_pct percent of the items are
  // starts that must be ignored because the command is still running.
  task automatic run_command(input logic [7:0] cmd, input logic [7:0] a0,
                             input logic [7:0] a1, input logic [7:0] a2,
                             input logic [1:0] count, input int busy_polls,
                             input logic [7:0] reply_val, input int stray_pct);
    twdcm_pkg::twdcm_in_t item;
    item              = random_item();
    item.kind         = 1'b1;
    item.command_byte = cmd;
    item.arg_first    = a0;
    item.arg_second   = a1;
    item.arg_third    = a2;
    item.arg_count    = count;
    send_item(item);
    commands_run++;
    while (mdl_phase != XFER_IDLE) begin
      item = random_item();
      if ($urandom_range(0, 99) < stray_pct) begin
        item.kind = 1'b1;
      end else begin
        item.kind = 1'b0;
        if (mdl_phase == XFER_READY_CHECK)
          item.dd_in = (mdl_polls < busy_polls);
        else if (mdl_phase == XFER_REPLY_READ && !mdl_half)
          item.dd_in = reply_val[7 - mdl_bit_idx];
      end
      send_item(item);
    end
  endtask

  // The register is only written with nothing in flight. Every item gives a
  // result, so once the last one is in, a short pause leaves the block idle.
  task automatic write_poll_limit(input logic [7:0] value);
    in_valid <= 1'b0;
    while (expected_levels_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    mdl_poll_limit = value;
  endtask

  // Ticks and field extremes while idle: the lines must stay at their reset
  // levels, DC low and DD driven low.
  task automatic test_idle_ticks();
    twdcm_pkg::twdcm_in_t item;
    item = '0;
    send_item(item);
    item = '1;
    item.kind = 1'b0;
    send_item(item);
    repeat (4) begin
      item      = random_item();
      item.kind = 1'b0;
      send_item(item);
    end
  endtask

  // Hand-picked commands: every argument count, all-zero and all-one bytes,
  // an immediate ready, a busy poll, and starts issued mid-command.
  task automatic test_directed_commands();
    run_command(8'h00, 8'h00, 8'h00, 8'h00, 2'd0, 0, 8'hFF, 0);
    run_command(8'hFF, 8'h00, 8'hFF, 8'h5A, 2'd3, 1, 8'h00, 20);
    run_command(8'hA5, 8'hFF, 8'h00, 8'h00, 2'd1, 1, 8'h81, 0);
    run_command(8'h3C, 8'h96, 8'h69, 8'hC3, 2'd2, 0, 8'h7E, 10);
  endtask

  // Poll limit boundaries: a limit of one that runs out, a limit of zero
  // (immediate timeout without a dummy read), a busy target right at a limit
  // of two, and the largest limit with a target that becomes ready.
  task automatic test_poll_limits();
    write_poll_limit(8'd1);
    run_command(8'h12, 8'h34, 8'h00, 8'h00, 2'd1, 5, 8'hC5, 0);
    write_poll_limit(8'd0);
    run_command(8'h80, 8'h00, 8'h00, 8'h00, 2'd0, 3, 8'h3A, 5);
    write_poll_limit(8'd2);
    run_command(8'h01, 8'h00, 8'h00, 8'h00, 2'd0, 2, 8'h55, 0);
    write_poll_limit(8'd255);
    run_command(8'h7F, 8'h01, 8'h00, 8'h00, 2'd1, 1, 8'h0F, 0);
    write_poll_limit(twdcm_pkg::POLL_LIMIT_RESET);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items with no gaps, so both internal registers fill and the input stalls.
  task automatic test_backpressure();
    sender_gaps_on = 1'b0;
    hold_request   = HOLD_CYCLES;
    run_command(8'h5A, 8'hA5, 8'h00, 8'h00, 2'd1, 1, 8'h99, 5);
    sender_gaps_on = 1'b1;
  endtask

  // Mostly well-formed commands with random content and small poll limits,
  // so that ready timeouts and dummy reads come often; the rest is idle
  // noise and register changes. Idling is switched per stretch.
  task automatic test_random_traffic();
    int                   start_count;
    int                   roll;
    int                   busy;
    twdcm_pkg::twdcm_in_t item;
    start_count = active_items;
    while (active_items - start_count < RANDOM_ITEMS) begin
      roll               = $urandom_range(0, 99);
      sender_gaps_on     = ($urandom_range(0, 3) != 0);
      receiver_stalls_on = ($urandom_range(0, 3) != 0);
      if (roll < 10) begin
        write_poll_limit(8'($urandom_range(0, 6)));
      end else if (roll < 20) begin
        repeat ($urandom_range(1, 4)) begin
          item      = random_item();
          item.kind = 1'b0;
          send_item(item);
        end
      end else begin
        busy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, mdl_poll_limit + 1)
                                           : $urandom_range(0, 1);
        run_command(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    2'($urandom_range(0, 3)), busy, 8'($urandom_range(0, 255)),
                    $urandom_range(0, 15));
      end
    end
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
  endtask

  // Receiver: random stalls of random length, plus the long hold-off that a
  // test can request, both counted down here cycle by cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && receiver_stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Each accepted result item is compared with the oldest expectation.
  always @(posedge clk) begin
    twdcm_pkg::twdcm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_levels_q.size() == 0) begin
        $error("result item arrived with no item outstanding");
        mismatches++;
      end else begin
        want = expected_levels_q.pop_front();
        results_checked++;
        check_field("clock_level", 8'(want.clock_level), 8'(out_data.clock_level));
        check_field("data_level", 8'(want.data_level), 8'(out_data.data_level));
        check_field("data_drive", 8'(want.data_drive), 8'(out_data.data_drive));
        check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
        check_field("reply", want.reply, out_data.reply);
        check_field("timed_out", 8'(want.timed_out), 8'(out_data.timed_out));
      end
    end
  end

  // Watchdog: too many cycles in a row without a handshake on either channel
  // means the block has hung.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) input_held_cycles++;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("two_wire_debug_command_master_core test failed");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    reset_predictor();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_directed_commands();
    test_poll_limits();
    test_backpressure();
    test_random_traffic();

    // Drain: wait for every outstanding result, then a few more cycles so
    // that any surplus result item would still be caught.
    in_valid <= 1'b0;
    while (expected_levels_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items in %0d commands and checked %0d results.",
             items_sent, commands_run, results_checked);
    $display("Ready waits that timed out: %0d; cycles with the input held off: %0d.",
             ready_timeouts, input_held_cycles);
    if (mismatches == 0) begin
      $display("two_wire_debug_command_master_core test passed");
    end else begin
      $display("two_wire_debug_command_master_core test failed");
    end
    $finish;
  end

endmodule
